/* rtl/usr_pkg.sv */
`timescale 1ns / 1ps
package usr_pkg;
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W = 8;
    localparam int CNT_W = 9;
    localparam int CHUNK_BYTES = 16;
    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_SX7 = 2'd1;
    localparam logic [1:0] KIND_SX8 = 2'd2;
    localparam logic [2:0] REG_MASK = 3'd0;
    localparam logic [2:0] REG_SX7_EN = 3'd1;
    localparam logic [2:0] REG_SX8_EN = 3'd2;
    localparam logic [2:0] REG_SX7_LIM = 3'd3;
    localparam logic [2:0] REG_SX8_LIM = 3'd4;
    localparam logic [2:0] REG_PASS_EN = 3'd5;
    localparam logic [3:0] ST_COMPLETE = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_CONT = 4'd2;
    localparam logic [3:0] ST_END = 4'd3;
    localparam logic [4:0] NO_OWNER = 5'd31;

    typedef struct packed {
        logic [31:0] w3;
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
    } words_t;

    typedef struct packed {
        logic [8:0]   message_length;
        logic [4:0]   chunk_bytes;
        logic [2:0]   out_nwords;
        logic [31:0]  out_word3;
        logic [31:0]  out_word2;
        logic [31:0]  out_word1;
        logic [31:0]  out_word0;
        logic [7:0]   out_stream;
        logic [3:0]   out_group;
        logic [1:0]   out_kind;
        logic         last_of_run;
    } result_t;

    function automatic logic [2:0] words_of_type(input logic [3:0] mt);
        case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: words_of_type = 3'd1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: words_of_type = 3'd2;
            4'hB, 4'hC: words_of_type = 3'd3;
            default: words_of_type = 3'd4;
        endcase
    endfunction
endpackage

/* rtl/ump_receive_sysex_reassembler.sv */
`timescale 1ns / 1ps
// channel | dir | payload
// s_axis  | in  | tdata[127:0] = in_word0..in_word3, word0 lowest
// m_axis  | out | tdata[159:0] = kind, group, stream, out_word0..3, nwords,
//         |     |   chunk_bytes, message_length, lowest first; tlast = last_of_run
// cfg     | in  | cfg_we, cfg_index, cfg_data
// End reads the stored message back chunk by chunk, since the single store
// port reads one byte a cycle.
// Reset: async, active low; stores are not cleared.
// A result waits in the output register; only the next result stalls on it.
module ump_receive_sysex_reassembler
    import usr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_word0, in_word1, in_word2, in_word3
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // kind, group, stream, out_word0..3, nwords,
                                         // chunk_bytes, message_length
    output logic         m_axis_tlast,   // last_of_run
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_APP  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [15:0] mask_reg;
    logic sx7_en_reg, sx8_en_reg, pass_en_reg;
    logic [8:0] lim7_reg, lim8_reg;
    logic [2:0] state_reg;
    words_t w_reg;
    logic [8:0] cnt7_reg, cnt8_reg;
    logic [4:0] own7_reg, own8_reg;
    logic [7:0] strm8_reg;
    logic sel8_reg, direct_reg, fin_reg;
    logic [3:0] nbytes_reg, bi_reg;
    logic [8:0] len_reg, off_reg;
    logic [4:0] ci_reg;
    logic [4:0] cb_reg;
    logic [127:0] acc_reg;
    logic [4:0] k_reg;
    logic [3:0] grp_reg;
    logic [7:0] sid_reg;
    result_t res_reg;
    logic ov_reg, rdv_reg;

    logic [3:0] mt, grp, st, nb;
    logic [127:0] pkt;
    logic [7:0] pbyte;
    logic [8:0] lim_eff, cnt_cur;
    logic [7:0] rd7, rd8, rdb;
    logic we7, we8;
    logic [7:0] waddr, raddr;
    logic more_chunks;

    assign mt = w_reg.w0[31:28];
    assign grp = w_reg.w0[27:24];
    assign st = w_reg.w0[23:20];
    assign nb = w_reg.w0[19:16];
    assign pkt = {w_reg.w0, w_reg.w1, w_reg.w2, w_reg.w3};
    // byte i of packet data: sx7 starts at pkt byte 2, sx8 at byte 3
    always_comb
    begin
        logic [3:0] pos;
        pos = sel8_reg ? 4'(bi_reg + 4'd3) : 4'(bi_reg + 4'd2);
        pbyte = pkt[127 - 8*pos -: 8];
        if (!sel8_reg)
        begin
            pbyte[7] = 1'b0;
        end
    end
    assign lim_eff = (sel8_reg ? lim8_reg : lim7_reg) > 9'(STORE_DEPTH) ?
                     9'(STORE_DEPTH) : (sel8_reg ? lim8_reg : lim7_reg);
    assign cnt_cur = sel8_reg ? cnt8_reg : cnt7_reg;
    assign waddr = cnt_cur[7:0];
    assign raddr = 8'(off_reg + 9'(ci_reg));
    assign we7 = state_reg == S_APP && !sel8_reg && bi_reg < nbytes_reg && cnt_cur < lim_eff;
    assign we8 = state_reg == S_APP && sel8_reg && bi_reg < nbytes_reg && cnt_cur < lim_eff;
    assign rdb = direct_reg ? pbyte : (sel8_reg ? rd8 : rd7);
    assign more_chunks = off_reg + 9'(cb_reg) < len_reg && k_reg < 5'd15;

    usr_store u_store7 (.clk(clk), .we(we7), .waddr(waddr), .wdata(pbyte),
                        .raddr(raddr), .rdata(rd7));
    usr_store u_store8 (.clk(clk), .we(we8), .waddr(waddr), .wdata(pbyte),
                        .raddr(raddr), .rdata(rd8));

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast = res_reg.last_of_run;
    assign m_axis_tdata = {1'b0, res_reg.message_length, res_reg.chunk_bytes,
                           res_reg.out_nwords, res_reg.out_word3, res_reg.out_word2,
                           res_reg.out_word1, res_reg.out_word0, res_reg.out_stream,
                           res_reg.out_group, res_reg.out_kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 16'hFFFF; sx7_en_reg <= 1'b1; sx8_en_reg <= 1'b1;
            lim7_reg <= 9'd256; lim8_reg <= 9'd256; pass_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MASK:    mask_reg <= cfg_data;
                REG_SX7_EN:  sx7_en_reg <= cfg_data[0];
                REG_SX8_EN:  sx8_en_reg <= cfg_data[0];
                REG_SX7_LIM: lim7_reg <= cfg_data[8:0];
                REG_SX8_LIM: lim8_reg <= cfg_data[8:0];
                REG_PASS_EN: pass_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; ov_reg <= 1'b0;
            cnt7_reg <= '0; cnt8_reg <= '0; own7_reg <= NO_OWNER; own8_reg <= NO_OWNER;
            strm8_reg <= '0;
        end
        else
        begin
            if (ov_reg && m_axis_tready && state_reg != S_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        w_reg <= s_axis_tdata;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    bi_reg <= '0; ci_reg <= '0; off_reg <= '0; k_reg <= '0;
                    acc_reg <= '0; rdv_reg <= 1'b0; grp_reg <= grp;
                    sel8_reg <= mt == 4'h5;
                    fin_reg <= st == ST_END;
                    direct_reg <= st == ST_COMPLETE;
                    state_reg <= S_IDLE;
                    if (mt == 4'h3)
                    begin
                        nbytes_reg <= nb > 4'd6 ? 4'd6 : nb;
                        sid_reg <= '0;
                        if (sx7_en_reg)
                        begin
                            if (st == ST_COMPLETE)
                            begin
                                len_reg <= 9'(nb > 4'd6 ? 4'd6 : nb);
                                state_reg <= S_RD;
                            end
                            else if (st == ST_START || 5'(grp) == own7_reg)
                            begin
                                own7_reg <= 5'(grp);
                                if (st == ST_START) cnt7_reg <= '0;
                                state_reg <= S_APP;
                            end
                            else
                            begin
                                own7_reg <= 5'(grp); cnt7_reg <= '0;
                                state_reg <= st == ST_CONT ? S_IDLE : S_APP;
                            end
                        end
                    end
                    else if (mt == 4'h5)
                    begin
                        nbytes_reg <= nb > 4'd14 ? 4'd13 : (nb > 4'd1 ? nb - 4'd1 : 4'd0);
                        sid_reg <= w_reg.w0[15:8];
                        if (sx8_en_reg)
                        begin
                            if (st == ST_COMPLETE)
                            begin
                                len_reg <= 9'(nb > 4'd14 ? 4'd13 :
                                              (nb > 4'd1 ? nb - 4'd1 : 4'd0));
                                state_reg <= S_RD;
                            end
                            else if (st == ST_START ||
                                     (5'(grp) == own8_reg && w_reg.w0[15:8] == strm8_reg))
                            begin
                                own8_reg <= 5'(grp); strm8_reg <= w_reg.w0[15:8];
                                if (st == ST_START) cnt8_reg <= '0;
                                state_reg <= S_APP;
                            end
                            else
                            begin
                                own8_reg <= 5'(grp); strm8_reg <= w_reg.w0[15:8];
                                cnt8_reg <= '0;
                                state_reg <= st == ST_CONT ? S_IDLE : S_APP;
                            end
                        end
                    end
                    else if (pass_en_reg && (mt == 4'h0 || mt == 4'hF || mask_reg[grp]))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_APP:
                begin
                    if (bi_reg < nbytes_reg)
                    begin
                        bi_reg <= bi_reg + 4'd1;
                        if (cnt_cur < lim_eff)
                        begin
                            if (sel8_reg) cnt8_reg <= cnt8_reg + 9'd1;
                            else cnt7_reg <= cnt7_reg + 9'd1;
                        end
                    end
                    else if (fin_reg)
                    begin
                        len_reg <= cnt_cur;
                        if (sel8_reg)
                        begin
                            sid_reg <= strm8_reg; cnt8_reg <= '0; own8_reg <= NO_OWNER;
                        end
                        else
                        begin
                            cnt7_reg <= '0; own7_reg <= NO_OWNER;
                        end
                        bi_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    // direct: bi_reg walks packet bytes; store: read data comes back the cycle after its address
                    if (direct_reg)
                    begin
                        if (5'(bi_reg) < 5'(len_reg))
                        begin
                            acc_reg[127 - 8*bi_reg -: 8] <= rdb;
                            bi_reg <= bi_reg + 4'd1;
                        end
                        else
                        begin
                            cb_reg <= 5'(len_reg);
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        if (rdv_reg)
                        begin
                            acc_reg[127 - 8*4'(ci_reg - 5'd1) -: 8] <= rdb;
                        end
                        if (ci_reg < 5'd16 && off_reg + 9'(ci_reg) < len_reg)
                        begin
                            ci_reg <= ci_reg + 5'd1;
                            rdv_reg <= 1'b1;
                        end
                        else if (rdv_reg)
                        begin
                            rdv_reg <= 1'b0;
                        end
                        else
                        begin
                            cb_reg <= ci_reg;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_reg <= 1'b1;
                        if (mt != 4'h3 && mt != 4'h5)
                        begin
                            res_reg.out_kind <= KIND_PASS;
                            res_reg.out_group <= grp;
                            res_reg.out_stream <= '0;
                            res_reg.out_word0 <= w_reg.w0;
                            res_reg.out_word1 <= words_of_type(mt) > 3'd1 ? w_reg.w1 : '0;
                            res_reg.out_word2 <= words_of_type(mt) > 3'd2 ? w_reg.w2 : '0;
                            res_reg.out_word3 <= words_of_type(mt) > 3'd3 ? w_reg.w3 : '0;
                            res_reg.out_nwords <= words_of_type(mt);
                            res_reg.chunk_bytes <= '0;
                            res_reg.message_length <= '0;
                            res_reg.last_of_run <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg.out_kind <= sel8_reg ? KIND_SX8 : KIND_SX7;
                            res_reg.out_group <= grp_reg;
                            res_reg.out_stream <= sid_reg;
                            res_reg.out_word0 <= acc_reg[127:96];
                            res_reg.out_word1 <= acc_reg[95:64];
                            res_reg.out_word2 <= acc_reg[63:32];
                            res_reg.out_word3 <= acc_reg[31:0];
                            res_reg.out_nwords <= '0;
                            res_reg.chunk_bytes <= cb_reg;
                            res_reg.message_length <= len_reg;
                            res_reg.last_of_run <= !more_chunks;
                            k_reg <= k_reg + 5'd1;
                            off_reg <= off_reg + 9'(cb_reg);
                            acc_reg <= '0; ci_reg <= '0; bi_reg <= '0;
                            state_reg <= more_chunks ? S_RD : S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/usr_store.sv */
`timescale 1ns / 1ps
module usr_store
    import usr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/usr_checker.sv */
`timescale 1ns / 1ps
module usr_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output changed while stalled");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad kind");
    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tlast)
        else $error("passthrough without last");
    a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[149:145] <= 5'd16)
        else $error("chunk too large");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken back to back");
endmodule

bind ump_receive_sysex_reassembler usr_checker u_usr_checker (.*);
